// ===== hdl/dfp_pkg.sv =====
`timescale 1ns / 1ps

package dfp_pkg;

    // field widths fixed by the number format
    localparam int CMD_W  = 3;
    localparam int FRAC_W = 14;

    // decimal fraction scale, four digits
    localparam logic [FRAC_W:0] DEC_SCALE = 15'd10000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GREATER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LESS    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EQUAL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEGATE  = 3'd5;

    // magnitude relation of the two operands
    typedef struct packed {
        logic a_gt;
        logic b_gt;
        logic eq;
    } t_mag_cmp;

endpackage

// ===== hdl/dfp_cmp.sv =====
`timescale 1ns / 1ps

module dfp_cmp #(
    parameter int INT_BITS = 31
) (
    input  logic [INT_BITS-1:0]       i_a_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_a_fraction,
    input  logic [INT_BITS-1:0]       i_b_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_b_fraction,
    output dfp_pkg::t_mag_cmp          o_cmp
);
    import dfp_pkg::*;

    logic int_eq;
    logic frac_eq;

    // integer part decides unless equal, then the fraction
    assign int_eq    = (i_a_integer == i_b_integer);
    assign frac_eq   = (i_a_fraction == i_b_fraction);
    assign o_cmp.a_gt = (i_a_integer > i_b_integer) ||
                        (int_eq && (i_a_fraction > i_b_fraction));
    assign o_cmp.b_gt = (i_b_integer > i_a_integer) ||
                        (int_eq && (i_b_fraction > i_a_fraction));
    assign o_cmp.eq   = int_eq && frac_eq;

endmodule

// ===== hdl/dfp_arith.sv =====
`timescale 1ns / 1ps

module dfp_arith #(
    parameter int INT_BITS = 31
) (
    input  logic                       i_sub,
    input  logic                       i_a_negative,
    input  logic [INT_BITS-1:0]        i_a_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_a_fraction,
    input  logic                       i_b_negative,
    input  logic [INT_BITS-1:0]        i_b_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_b_fraction,
    input  dfp_pkg::t_mag_cmp          i_cmp,
    output logic                       o_negative,
    output logic [INT_BITS-1:0]        o_integer,
    output logic [dfp_pkg::FRAC_W-1:0] o_fraction,
    output logic                       o_overflow
);
    import dfp_pkg::*;

    logic                eff_add;
    logic [FRAC_W:0]     frac_sum;
    logic                frac_carry;
    logic [FRAC_W:0]     frac_sum_adj;
    logic [INT_BITS:0]   int_sum;
    logic                borrow_ab;
    logic                borrow_ba;
    logic [FRAC_W:0]     frac_ab;
    logic [FRAC_W:0]     frac_ba;
    logic [INT_BITS-1:0] int_ab;
    logic [INT_BITS-1:0] int_ba;
    logic                a_is_pos;
    logic                take_ab;
    logic                diff_neg;

    // signs decide between a magnitude add and a magnitude subtract
    assign eff_add = i_sub ? (i_a_negative != i_b_negative)
                           : (i_a_negative == i_b_negative);

    // magnitude add with decimal carry
    assign frac_sum     = {1'b0, i_a_fraction} + {1'b0, i_b_fraction};
    assign frac_carry   = (frac_sum >= DEC_SCALE);
    assign frac_sum_adj = frac_carry ? (frac_sum - DEC_SCALE) : frac_sum;
    assign int_sum      = {1'b0, i_a_integer} + {1'b0, i_b_integer}
                        + {{INT_BITS{1'b0}}, frac_carry};

    // both differences in parallel, chosen after the compare
    assign borrow_ab = (i_a_fraction < i_b_fraction);
    assign borrow_ba = (i_b_fraction < i_a_fraction);
    assign frac_ab   = borrow_ab ? ({1'b0, i_a_fraction} + DEC_SCALE - {1'b0, i_b_fraction})
                                 : ({1'b0, i_a_fraction} - {1'b0, i_b_fraction});
    assign frac_ba   = borrow_ba ? ({1'b0, i_b_fraction} + DEC_SCALE - {1'b0, i_a_fraction})
                                 : ({1'b0, i_b_fraction} - {1'b0, i_a_fraction});
    assign int_ab    = i_a_integer - i_b_integer - {{(INT_BITS-1){1'b0}}, borrow_ab};
    assign int_ba    = i_b_integer - i_a_integer - {{(INT_BITS-1){1'b0}}, borrow_ba};

    // the larger magnitude is the minuend; on a tie a is the minuend only when a is negative
    assign a_is_pos = !i_a_negative;
    assign take_ab  = a_is_pos ? i_cmp.a_gt : !i_cmp.b_gt;
    assign diff_neg = a_is_pos ? !i_cmp.a_gt : !i_cmp.b_gt;

    // select add or subtract result
    always_comb begin
        if (eff_add) begin
            o_negative = i_a_negative;
            o_integer  = int_sum[INT_BITS-1:0];
            o_fraction = frac_sum_adj[FRAC_W-1:0];
            o_overflow = int_sum[INT_BITS];
        end else begin
            o_negative = diff_neg;
            o_integer  = take_ab ? int_ab : int_ba;
            o_fraction = take_ab ? frac_ab[FRAC_W-1:0] : frac_ba[FRAC_W-1:0];
            o_overflow = 1'b0;
        end
    end

endmodule

// ===== hdl/decimal_fixed_point_add_sub_compare_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// command   in         start high, busy low      i_command, i_a_*, i_b_*
// result    out        o_done, one cycle strobe  o_result_*, o_compare_true, o_overflow
//
// one operation per clock, every cycle while out of reset, registered in r_in_vld and then r_done to o_done
// operands land in an input register, a single pass of compare and add/subtract
// logic feeds the result register
// busy is high only while i_rst_n is low; reset clears the valid bits
// the receiver cannot stall, so results flow out as they are produced
module decimal_fixed_point_add_sub_compare_top #(
    parameter int INT_BITS = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dfp_pkg::CMD_W-1:0]  i_command,
    input  logic                       i_a_negative,
    input  logic [INT_BITS-1:0]        i_a_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_a_fraction,
    input  logic                       i_b_negative,
    input  logic [INT_BITS-1:0]        i_b_integer,
    input  logic [dfp_pkg::FRAC_W-1:0] i_b_fraction,
    output logic                       o_done,
    output logic                       o_result_negative,
    output logic [INT_BITS-1:0]        o_result_integer,
    output logic [dfp_pkg::FRAC_W-1:0] o_result_fraction,
    output logic                       o_compare_true,
    output logic                       o_overflow
);
    import dfp_pkg::*;

    logic                r_in_vld;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_a_neg;
    logic [INT_BITS-1:0] r_a_int;
    logic [FRAC_W-1:0]   r_a_frac;
    logic                r_b_neg;
    logic [INT_BITS-1:0] r_b_int;
    logic [FRAC_W-1:0]   r_b_frac;

    logic                r_done;
    logic                r_res_neg;
    logic [INT_BITS-1:0] r_res_int;
    logic [FRAC_W-1:0]   r_res_frac;
    logic                r_cmp_true;
    logic                r_ovf;

    logic                n_res_neg;
    logic [INT_BITS-1:0] n_res_int;
    logic [FRAC_W-1:0]   n_res_frac;
    logic                n_cmp_true;
    logic                n_ovf;

    t_mag_cmp            mag_cmp;
    logic                ar_neg;
    logic [INT_BITS-1:0] ar_int;
    logic [FRAC_W-1:0]   ar_frac;
    logic                ar_ovf;
    logic                a_num_gt;
    logic                b_num_gt;
    logic                accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_a_neg  <= i_a_negative;
            r_a_int  <= i_a_integer;
            r_a_frac <= i_a_fraction;
            r_b_neg  <= i_b_negative;
            r_b_int  <= i_b_integer;
            r_b_frac <= i_b_fraction;
        end
    end

    dfp_cmp #(
        .INT_BITS(INT_BITS)
    ) u_cmp (
        .i_a_integer (r_a_int),
        .i_a_fraction(r_a_frac),
        .i_b_integer (r_b_int),
        .i_b_fraction(r_b_frac),
        .o_cmp       (mag_cmp)
    );

    dfp_arith #(
        .INT_BITS(INT_BITS)
    ) u_arith (
        .i_sub       (r_cmd == CMD_SUB),
        .i_a_negative(r_a_neg),
        .i_a_integer (r_a_int),
        .i_a_fraction(r_a_frac),
        .i_b_negative(r_b_neg),
        .i_b_integer (r_b_int),
        .i_b_fraction(r_b_frac),
        .i_cmp       (mag_cmp),
        .o_negative  (ar_neg),
        .o_integer   (ar_int),
        .o_fraction  (ar_frac),
        .o_overflow  (ar_ovf)
    );

    // signed ordering, +0 ranks above -0
    assign a_num_gt = (r_a_neg != r_b_neg) ? !r_a_neg
                    : (r_a_neg ? mag_cmp.b_gt : mag_cmp.a_gt);
    assign b_num_gt = (r_a_neg != r_b_neg) ? !r_b_neg
                    : (r_a_neg ? mag_cmp.a_gt : mag_cmp.b_gt);

    // command select
    always_comb begin
        n_res_neg  = 1'b0;
        n_res_int  = '0;
        n_res_frac = '0;
        n_cmp_true = 1'b0;
        n_ovf      = 1'b0;
        unique case (r_cmd)
            CMD_ADD, CMD_SUB: begin
                n_res_neg  = ar_neg;
                n_res_int  = ar_int;
                n_res_frac = ar_frac;
                n_ovf      = ar_ovf;
            end
            CMD_GREATER: n_cmp_true = a_num_gt;
            CMD_LESS:    n_cmp_true = b_num_gt;
            CMD_EQUAL:   n_cmp_true = (r_a_neg == r_b_neg) && mag_cmp.eq;
            CMD_NEGATE: begin
                n_res_neg  = !r_a_neg;
                n_res_int  = r_a_int;
                n_res_frac = r_a_frac;
            end
            default: begin
                n_res_neg  = 1'b0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_res_neg  <= n_res_neg;
            r_res_int  <= n_res_int;
            r_res_frac <= n_res_frac;
            r_cmp_true <= n_cmp_true;
            r_ovf      <= n_ovf;
        end
    end

    assign o_done            = r_done;
    assign o_result_negative = r_res_neg;
    assign o_result_integer  = r_res_int;
    assign o_result_fraction = r_res_frac;
    assign o_compare_true    = r_cmp_true;
    assign o_overflow        = r_ovf;

    // every transfer yields a strobe on o_done once it has passed r_in_vld and r_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("result strobe missing after transfer");

    // a compare outcome never comes with arithmetic fields
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_compare_true) |-> (!o_overflow && !o_result_negative &&
            o_result_integer == '0 && o_result_fraction == '0))
        else $error("compare result carries arithmetic fields");

    // no strobe without an earlier transfer registered in r_in_vld
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_vld))
        else $error("result strobe without transfer");

endmodule
